// File: design/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared constants, types and compare function for the binary heap queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int CAPACITY  = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   // item kinds
   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // order mode
   localparam logic ORDER_MAX = 1'b0;
   localparam logic ORDER_MIN = 1'b1;

   // one memory access slot: one write and one read per cycle
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [1:0] status;
      key_type    top;
      cnt_type    count;
   } result_type;

   // true when a must sit strictly above b
   function automatic logic beats(input key_type a, input key_type b, input logic mode);
      if (mode == ORDER_MIN) begin
         return a < b;
      end
      return a > b;
   endfunction

endpackage

// File: design/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram
// Heap key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram
   import bhpq_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output key_type     rd_data
);

   key_type heap_mem_ff [CAPACITY];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         heap_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= heap_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bhpq_engine.sv
// ----------------------------------------------------------------------------
// bhpq_engine
// Sequencer for insert (sift up) and extract (sift down) over the key store.
// ----------------------------------------------------------------------------
module bhpq_engine
   import bhpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        kind,
   input  key_type     value,
   input  logic        order_mode,
   input  logic        res_ready,
   input  key_type     rd_data,
   output logic        idle,
   output logic        done,
   output result_type  result,
   output mem_req_type mem_req
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UP      = 3'd1;
   localparam logic [2:0] ST_EX_TOP  = 3'd2;
   localparam logic [2:0] ST_EX_LAST = 3'd3;
   localparam logic [2:0] ST_DN_L    = 3'd4;
   localparam logic [2:0] ST_DN_R    = 3'd5;
   localparam logic [2:0] ST_WR_KEY  = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   logic [2:0] state_ff, state_in;
   cnt_type    cnt_ff, cnt_in;
   addr_type   pos_ff, pos_in;
   key_type    key_ff, key_in;
   key_type    lval_ff, lval_in;
   logic [1:0] status_ff, status_in;
   key_type    top_ff, top_in;

   // index arithmetic for the current slot
   cnt_type  left_w, right_w, half_cnt, cnt_dec;
   addr_type parent_idx;
   // child move decision
   logic     take_child;
   key_type  child_val;
   addr_type child_idx;
   key_type  best_lk;
   cnt_type  child_left_w;

   assign left_w     = {pos_ff, 1'b1};
   assign right_w    = left_w + cnt_type'(1);
   assign half_cnt   = cnt_ff >> 1;
   assign cnt_dec    = cnt_ff - cnt_type'(1);
   assign parent_idx = (pos_ff - addr_type'(1)) >> 1;

   always_comb begin
      take_child = 1'b0;
      child_val  = rd_data;
      child_idx  = left_w[ADDR_W-1:0];
      best_lk    = key_ff;
      if (state_ff == ST_DN_R) begin
         // left is in lval_ff, right is on the read port; left wins ties
         if (beats(lval_ff, key_ff, order_mode)) begin
            best_lk    = lval_ff;
            take_child = 1'b1;
            child_val  = lval_ff;
         end
         if (beats(rd_data, best_lk, order_mode)) begin
            take_child = 1'b1;
            child_val  = rd_data;
            child_idx  = right_w[ADDR_W-1:0];
         end
      end else begin
         take_child = beats(rd_data, key_ff, order_mode);
      end
   end

   assign child_left_w = {child_idx, 1'b1};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      lval_in   = lval_ff;
      status_in = status_ff;
      top_in    = top_ff;
      mem_req   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in = STAT_OK;
               top_in    = '0;
               key_in    = value;
               if (kind == KIND_INSERT) begin
                  if (cnt_ff == cnt_type'(CAPACITY)) begin
                     status_in = STAT_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     pos_in = cnt_ff[ADDR_W-1:0];
                     cnt_in = cnt_ff + cnt_type'(1);
                     if (cnt_ff == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = value;
                        state_in        = ST_DONE;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = (cnt_ff[ADDR_W-1:0] - addr_type'(1)) >> 1;
                        state_in        = ST_UP;
                     end
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     state_in        = ST_EX_TOP;
                  end
               end
            end
         end
         ST_UP: begin
            // parent key is on the read port
            if (beats(key_ff, rd_data, order_mode)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = rd_data;
               pos_in          = parent_idx;
               if (parent_idx == '0) begin
                  state_in = ST_WR_KEY;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = (parent_idx - addr_type'(1)) >> 1;
               end
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = key_ff;
               state_in        = ST_DONE;
            end
         end
         ST_EX_TOP: begin
            top_in = rd_data;
            cnt_in = cnt_dec;
            if (cnt_dec == '0) begin
               state_in = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cnt_dec[ADDR_W-1:0];
               state_in        = ST_EX_LAST;
            end
         end
         ST_EX_LAST: begin
            // last key moves to the root and sinks from there
            key_in = rd_data;
            pos_in = '0;
            if (cnt_ff > cnt_type'(1)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = addr_type'(1);
               state_in        = ST_DN_L;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = '0;
               mem_req.wr_data = rd_data;
               state_in        = ST_DONE;
            end
         end
         ST_DN_L, ST_DN_R: begin
            if (state_ff == ST_DN_L && right_w < cnt_ff) begin
               lval_in         = rd_data;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = right_w[ADDR_W-1:0];
               state_in        = ST_DN_R;
            end else if (take_child) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = child_val;
               pos_in          = child_idx;
               if (cnt_type'(child_idx) < half_cnt) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = child_left_w[ADDR_W-1:0];
                  state_in        = ST_DN_L;
               end else begin
                  state_in = ST_WR_KEY;
               end
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = key_ff;
               state_in        = ST_DONE;
            end
         end
         ST_WR_KEY: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = key_ff;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      lval_ff   <= lval_in;
      status_ff <= status_in;
      top_ff    <= top_in;
   end

   assign idle          = (state_ff == ST_IDLE);
   assign done          = (state_ff == ST_DONE);
   assign result.status = status_ff;
   assign result.top    = top_ff;
   assign result.count  = cnt_ff;

endmodule

// File: design/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-based binary heap: insert a key or extract the top key per item.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_stall   req_kind, req_item_value
//  rsp_      out        rsp_valid / rsp_stall   rsp_status, rsp_top_value,
//                                               rsp_item_count
//  csr_      in         csr_write_en            csr_write_data (order_mode)
//
//  One item is worked at a time. Insert: one parent read per level of sift
//  up. Extract: up to two reads per level of sift down, through the single
//  read port of the key store. Reset clears the count and order mode; the
//  key store is not cleared. A result waits in the output register while
//  the next item is worked; the engine holds its finished result until that
//  register frees up.
//
module binary_heap_priority_queue
   import bhpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_item_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_top_value,
   output logic [10:0] rsp_item_count,

   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   logic        order_ff;
   logic        eng_idle, eng_done, res_ready, start;
   result_type  eng_result;
   mem_req_type mem_req;
   key_type     rd_data;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   // order mode; the user must write it only while the queue is idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_MAX;
      end else if (csr_write_en) begin
         order_ff <= csr_write_data;
      end
   end

   assign req_stall = !eng_idle;
   assign start     = req_valid && eng_idle;
   // output register is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   bhpq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .kind       (req_kind),
      .value      (req_item_value),
      .order_mode (order_ff),
      .res_ready  (res_ready),
      .rd_data    (rd_data),
      .idle       (eng_idle),
      .done       (eng_done),
      .result     (eng_result),
      .mem_req    (mem_req)
   );

   bhpq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_done && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (eng_done && res_ready) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_top_value  = rsp_data_ff.top;
   assign rsp_item_count = rsp_data_ff.count;

endmodule
